>>> hdl/inner_hair_cell_synapse_top_defines.svh
// assertion helpers shared by the synapse rtl
`ifndef INNER_HAIR_CELL_SYNAPSE_TOP_DEFINES_SVH
`define INNER_HAIR_CELL_SYNAPSE_TOP_DEFINES_SVH

// same-cycle implication, checked while out of reset
`define IHCS_ASSERT_IMP(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);

// next-cycle implication, checked while out of reset
`define IHCS_ASSERT_NXT(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);

`endif

>>> hdl/ihcs_pkg.sv
package ihcs_pkg;

  localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;

  // register map of the configuration port
  typedef enum logic [2:0] {
    REG_PERM_A    = 3'd0,
    REG_PERM_B    = 3'd1,
    REG_RELEASE   = 3'd2,
    REG_REPLENISH = 3'd3,
    REG_REPROCESS = 3'd4,
    REG_RECOVERY  = 3'd5,
    REG_LOSS_REC  = 3'd6,
    REG_FIRING    = 3'd7
  } cfg_reg_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_KDIV,
    ST_KMUL,
    ST_S1,
    ST_S2,
    ST_S3,
    ST_S4,
    ST_S5,
    ST_S6,
    ST_E1,
    ST_E2,
    ST_E3,
    ST_ENORM,
    ST_EDIV1,
    ST_ET,
    ST_ER,
    ST_EDIV2,
    ST_EQ,
    ST_EDIV3,
    ST_EW,
    ST_EW2,
    ST_EDIV4,
    ST_WRITE,
    ST_SPK
  } state_t;

  // one memory word holds all three stores of a channel
  typedef struct packed {
    logic [31:0] q;
    logic [31:0] c;
    logic [31:0] w;
  } chan_state_t;

  typedef struct packed {
    logic        start;
    logic [6:0]  steps;
    logic [33:0] rem0;
    logic [63:0] dvd;
    logic [33:0] den;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [64:0] quo;
    logic [33:0] rem;
  } div_rsp_t;

endpackage

>>> hdl/inner_hair_cell_synapse_top.sv
// Three-reservoir transmitter synapse for NUM_CHANNELS channels. Each channel's free pool,
// cleft and reprocess stores (unsigned Q2.30) sit in one on-chip memory word that is read when
// a transaction is accepted and written back once its update is done; one transaction is in
// work at a time, while a finished result may still wait in the output register. A sample
// transaction (kind 0) needs at most the 33-step permeability division; an initialise
// transaction (kind 1) needs up to that division, up to 33 normalize shifts and four 65-step
// divisions, all on one shared restoring divider and one 32x32 multiplier. After reset a
// clearing pass zeroes the stores of all NUM_CHANNELS channels and no transaction is taken
// until it ends; configuration writes are taken at any time but must only be made while the
// block is idle. Channels at or above NUM_CHANNELS return zero and leave all stores untouched.
`include "inner_hair_cell_synapse_top_defines.svh"
module inner_hair_cell_synapse_top #(
  parameter int          NUM_CHANNELS = 64,
  parameter logic [31:0] FULL_POOL    = 32'd1073741824
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_kind,
  input  logic [5:0]  in_channel,
  input  logic signed [31:0] in_stimulus,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  out_channel_out,
  output logic [31:0] out_spike_probability
);
  import ihcs_pkg::*;

  localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam logic [10:0] NCH = 11'(NUM_CHANNELS);

  // configuration registers
  logic [31:0] cfg_a_r, cfg_b_r, cfg_g_r, cfg_y_r, cfg_x_r, cfg_r_r, cfg_lr_r, cfg_h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_a_r  <= 32'd6553600;
      cfg_b_r  <= 32'd393216000;
      cfg_g_r  <= 32'd85899346;
      cfg_y_r  <= 32'd216895;
      cfg_x_r  <= 32'd2847930;
      cfg_r_r  <= 32'd282604986;
      cfg_lr_r <= 32'd389979169;
      cfg_h_r  <= 32'd2147483648;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_PERM_A:    cfg_a_r  <= cfg_data;
        REG_PERM_B:    cfg_b_r  <= cfg_data;
        REG_RELEASE:   cfg_g_r  <= cfg_data;
        REG_REPLENISH: cfg_y_r  <= cfg_data;
        REG_REPROCESS: cfg_x_r  <= cfg_data;
        REG_RECOVERY:  cfg_r_r  <= cfg_data;
        REG_LOSS_REC:  cfg_lr_r <= cfg_data;
        REG_FIRING:    cfg_h_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // store memory
  chan_state_t store_mem [NUM_CHANNELS];
  chan_state_t rd_r;
  logic        mem_we;
  logic [AW-1:0] mem_addr;
  chan_state_t mem_wd;
  logic        mem_re;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_mem[mem_addr] <= mem_wd;
    end
    if (mem_re) begin
      rd_r <= store_mem[AW'(in_channel)];
    end
  end

  // divider
  div_req_t div_req;
  div_rsp_t div_rsp;

  ihcs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // shared multiplier
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  assign mul_p = mul_a * mul_b;

  state_t        state_r, state_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic          kind_r, kind_nxt;
  logic [5:0]    ch_r, ch_nxt;
  logic [31:0]   stim_r, stim_nxt;
  logic [31:0]   k_r, k_nxt;
  logic [64:0]   acc_r, acc_nxt;
  logic [63:0]   a_r, a_nxt;
  logic [63:0]   t_r, t_nxt;
  logic [63:0]   prod_r, prod_nxt;
  logic [31:0]   repl_r, repl_nxt, back_r, back_nxt, eject_r, eject_nxt;
  logic [31:0]   uptake_r, uptake_nxt, gone_r, gone_nxt;
  logic [31:0]   nq_r, nq_nxt, nc_r, nc_nxt, nw_r, nw_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [5:0]    out_ch_r, out_ch_nxt;
  logic [31:0]   out_sp_r, out_sp_nxt;

  logic [33:0] t_perm;
  logic        t_pos;
  logic [31:0] lossd;
  logic [34:0] sum_q, sum_c, sum_w;
  logic [32:0] sum_c0;

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    kind_nxt      = kind_r;
    ch_nxt        = ch_r;
    stim_nxt      = stim_r;
    k_nxt         = k_r;
    acc_nxt       = acc_r;
    a_nxt         = a_r;
    t_nxt         = t_r;
    prod_nxt      = prod_r;
    repl_nxt      = repl_r;
    back_nxt      = back_r;
    eject_nxt     = eject_r;
    uptake_nxt    = uptake_r;
    gone_nxt      = gone_r;
    nq_nxt        = nq_r;
    nc_nxt        = nc_r;
    nw_nxt        = nw_r;
    out_valid_nxt = out_valid_r;
    out_ch_nxt    = out_ch_r;
    out_sp_nxt    = out_sp_r;
    in_ready      = 1'b0;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_addr      = AW'(ch_r);
    mem_wd        = '{q: nq_r, c: nc_r, w: nw_r};
    mul_a         = '0;
    mul_b         = '0;
    div_req       = '0;

    t_perm = {2'b00, cfg_a_r} + (kind_r ? 34'd0 : {{2{stim_r[31]}}, stim_r});
    t_pos  = !t_perm[33] && (t_perm != 34'd0);
    lossd  = (cfg_lr_r >= cfg_r_r) ? (cfg_lr_r - cfg_r_r) : 32'd0;
    sum_q  = {3'b000, rd_r.q} + {3'b000, repl_r} - {3'b000, eject_r} + {3'b000, back_r};
    sum_c  = {3'b000, rd_r.c} + {3'b000, eject_r} - {3'b000, gone_r};
    sum_w  = {3'b000, rd_r.w} + {3'b000, uptake_r} - {3'b000, back_r};
    sum_c0 = {1'b0, t_r[31:0]} + div_rsp.quo[32:0];

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = clr_r;
        mem_wd   = '0;
        clr_nxt  = clr_r + AW'(1);
        if (clr_r == AW'(NUM_CHANNELS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          kind_nxt = in_kind;
          ch_nxt   = in_channel;
          stim_nxt = in_stimulus;
          if (11'(in_channel) < NCH) begin
            mem_re    = 1'b1;
            state_nxt = ST_READ;
          end else begin
            prod_nxt  = '0;
            state_nxt = ST_SPK;
          end
        end
      end
      ST_READ: begin
        if (t_pos) begin
          div_req.start = 1'b1;
          div_req.steps = 7'd32;
          div_req.rem0  = t_perm;
          div_req.dvd   = '0;
          div_req.den   = t_perm + {2'b00, cfg_b_r};
          state_nxt     = ST_KDIV;
        end else begin
          k_nxt     = '0;
          state_nxt = kind_r ? ST_E1 : ST_S1;
        end
      end
      ST_KDIV: begin
        if (div_rsp.done) begin
          state_nxt = ST_KMUL;
        end
      end
      ST_KMUL: begin
        mul_a     = cfg_g_r;
        mul_b     = div_rsp.quo[31:0];
        k_nxt     = div_rsp.quo[32] ? cfg_g_r : mul_p[63:32];
        state_nxt = kind_r ? ST_E1 : ST_S1;
      end
      ST_S1: begin
        mul_a     = cfg_y_r;
        mul_b     = FULL_POOL - rd_r.q;
        repl_nxt  = (rd_r.q < FULL_POOL) ? mul_p[63:32] : 32'd0;
        state_nxt = ST_S2;
      end
      ST_S2: begin
        mul_a     = cfg_x_r;
        mul_b     = rd_r.w;
        back_nxt  = mul_p[63:32];
        state_nxt = ST_S3;
      end
      ST_S3: begin
        mul_a     = k_r;
        mul_b     = rd_r.q;
        eject_nxt = mul_p[63:32];
        state_nxt = ST_S4;
      end
      ST_S4: begin
        mul_a      = cfg_r_r;
        mul_b      = rd_r.c;
        uptake_nxt = mul_p[63:32];
        state_nxt  = ST_S5;
      end
      ST_S5: begin
        mul_a     = cfg_lr_r;
        mul_b     = rd_r.c;
        gone_nxt  = mul_p[63:32];
        state_nxt = ST_S6;
      end
      ST_S6: begin
        // clamp each store to the unsigned 32-bit range
        nq_nxt    = sum_q[34] ? 32'd0 : ((sum_q[33:32] != 2'd0) ? MAX32 : sum_q[31:0]);
        nc_nxt    = sum_c[34] ? 32'd0 : ((sum_c[33:32] != 2'd0) ? MAX32 : sum_c[31:0]);
        nw_nxt    = sum_w[34] ? 32'd0 : ((sum_w[33:32] != 2'd0) ? MAX32 : sum_w[31:0]);
        state_nxt = ST_WRITE;
      end
      ST_E1: begin
        mul_a     = cfg_y_r;
        mul_b     = cfg_lr_r;
        acc_nxt   = {1'b0, mul_p};
        state_nxt = ST_E2;
      end
      ST_E2: begin
        mul_a     = k_r;
        mul_b     = lossd;
        t_nxt     = mul_p;
        state_nxt = ST_E3;
      end
      ST_E3: begin
        acc_nxt   = acc_r + {1'b0, t_r};
        mul_a     = cfg_y_r;
        mul_b     = k_r;
        a_nxt     = mul_p;
        state_nxt = ST_ENORM;
      end
      ST_ENORM: begin
        // shift divisor and dividend together until the divisor fits 32 bits
        if (acc_r[64:32] != 33'd0) begin
          acc_nxt = {1'b0, acc_r[64:1]};
          a_nxt   = {1'b0, a_r[63:1]};
        end else if (acc_r[31:0] == 32'd0) begin
          nc_nxt    = '0;
          state_nxt = ST_EQ;
        end else begin
          div_req.start = 1'b1;
          div_req.steps = 7'd64;
          div_req.rem0  = '0;
          div_req.dvd   = a_r;
          div_req.den   = {2'b00, acc_r[31:0]};
          state_nxt     = ST_EDIV1;
        end
      end
      ST_EDIV1: begin
        if (div_rsp.done) begin
          if (div_rsp.quo[64:32] != 33'd0) begin
            nc_nxt    = MAX32;
            state_nxt = ST_EQ;
          end else begin
            state_nxt = ST_ET;
          end
        end
      end
      ST_ET: begin
        mul_a     = FULL_POOL;
        mul_b     = div_rsp.quo[31:0];
        t_nxt     = mul_p;
        state_nxt = ST_ER;
      end
      ST_ER: begin
        if (t_r[63:32] != 32'd0) begin
          nc_nxt    = MAX32;
          state_nxt = ST_EQ;
        end else begin
          // fractional part of the quotient, scaled by the full pool
          mul_a         = FULL_POOL;
          mul_b         = div_rsp.rem[31:0];
          div_req.start = 1'b1;
          div_req.steps = 7'd64;
          div_req.rem0  = '0;
          div_req.dvd   = mul_p;
          div_req.den   = {2'b00, acc_r[31:0]};
          state_nxt     = ST_EDIV2;
        end
      end
      ST_EDIV2: begin
        if (div_rsp.done) begin
          nc_nxt    = sum_c0[32] ? MAX32 : sum_c0[31:0];
          state_nxt = ST_EQ;
        end
      end
      ST_EQ: begin
        if (k_r == 32'd0) begin
          nq_nxt    = FULL_POOL;
          state_nxt = ST_EW;
        end else begin
          mul_a         = nc_r;
          mul_b         = cfg_lr_r;
          div_req.start = 1'b1;
          div_req.steps = 7'd64;
          div_req.rem0  = '0;
          div_req.dvd   = mul_p;
          div_req.den   = {2'b00, k_r};
          state_nxt     = ST_EDIV3;
        end
      end
      ST_EDIV3: begin
        if (div_rsp.done) begin
          nq_nxt    = (div_rsp.quo[64:32] != 33'd0) ? MAX32 : div_rsp.quo[31:0];
          state_nxt = ST_EW;
        end
      end
      ST_EW: begin
        mul_a     = nc_r;
        mul_b     = cfg_r_r;
        t_nxt     = mul_p;
        state_nxt = ST_EW2;
      end
      ST_EW2: begin
        if (cfg_x_r == 32'd0) begin
          nw_nxt    = (t_r != 64'd0) ? MAX32 : 32'd0;
          state_nxt = ST_WRITE;
        end else begin
          div_req.start = 1'b1;
          div_req.steps = 7'd64;
          div_req.rem0  = '0;
          div_req.dvd   = t_r;
          div_req.den   = {2'b00, cfg_x_r};
          state_nxt     = ST_EDIV4;
        end
      end
      ST_EDIV4: begin
        if (div_rsp.done) begin
          nw_nxt    = (div_rsp.quo[64:32] != 33'd0) ? MAX32 : div_rsp.quo[31:0];
          state_nxt = ST_WRITE;
        end
      end
      ST_WRITE: begin
        mem_we    = 1'b1;
        mul_a     = cfg_h_r;
        mul_b     = nc_r;
        prod_nxt  = mul_p;
        state_nxt = ST_SPK;
      end
      ST_SPK: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_ch_nxt    = ch_r;
          out_sp_nxt    = (prod_r[63:62] != 2'd0) ? MAX32 : prod_r[61:30];
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r   <= kind_nxt;
    ch_r     <= ch_nxt;
    stim_r   <= stim_nxt;
    k_r      <= k_nxt;
    acc_r    <= acc_nxt;
    a_r      <= a_nxt;
    t_r      <= t_nxt;
    prod_r   <= prod_nxt;
    repl_r   <= repl_nxt;
    back_r   <= back_nxt;
    eject_r  <= eject_nxt;
    uptake_r <= uptake_nxt;
    gone_r   <= gone_nxt;
    nq_r     <= nq_nxt;
    nc_r     <= nc_nxt;
    nw_r     <= nw_nxt;
    out_ch_r <= out_ch_nxt;
    out_sp_r <= out_sp_nxt;
  end

  assign out_valid             = out_valid_r;
  assign out_channel_out       = out_ch_r;
  assign out_spike_probability = out_sp_r;

  `IHCS_ASSERT_NXT(a_accept_leaves_idle, in_valid && in_ready, state_r != ST_IDLE, "transaction accepted but sequencer stayed idle")
  `IHCS_ASSERT_IMP(a_div_done_awaited, div_rsp.done, state_r == ST_KDIV || state_r == ST_EDIV1 || state_r == ST_EDIV2 || state_r == ST_EDIV3 || state_r == ST_EDIV4, "divider finished with nobody waiting")
  `IHCS_ASSERT_NXT(a_release_bounded, state_r == ST_KMUL, k_r <= cfg_g_r, "release step above its rate")
  `IHCS_ASSERT_IMP(a_div_start_idle, div_req.start, !div_rsp.busy, "divider started while busy")

endmodule

>>> hdl/ihcs_div.sv
module ihcs_div (
  input  logic               clk,
  input  logic               rst_n,
  input  ihcs_pkg::div_req_t req,
  output ihcs_pkg::div_rsp_t rsp
);
  import ihcs_pkg::*;

  logic        busy_r;
  logic        done_r;
  logic        first_r;
  logic [6:0]  cnt_r;
  logic [33:0] rem_r;
  logic [63:0] dvd_r;
  logic [33:0] den_r;
  logic [64:0] quo_r;

  logic [34:0] cand;
  logic [34:0] diff;
  logic        ge;
  logic [33:0] rem_nxt;

  // first step compares the preloaded remainder, later steps shift in one bit
  always_comb begin
    cand    = first_r ? {1'b0, rem_r} : {rem_r, dvd_r[63]};
    diff    = cand - {1'b0, den_r};
    ge      = (cand >= {1'b0, den_r});
    rem_nxt = ge ? diff[33:0] : cand[33:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      first_r <= 1'b0;
      cnt_r   <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start && !busy_r) begin
        busy_r  <= 1'b1;
        first_r <= 1'b1;
        cnt_r   <= req.steps;
      end else if (busy_r) begin
        if (first_r) begin
          first_r <= 1'b0;
        end else begin
          cnt_r <= cnt_r - 7'd1;
          if (cnt_r == 7'd1) begin
            busy_r <= 1'b0;
            done_r <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start && !busy_r) begin
      rem_r <= req.rem0;
      dvd_r <= req.dvd;
      den_r <= req.den;
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[63:0], ge};
      if (!first_r) begin
        dvd_r <= {dvd_r[62:0], 1'b0};
      end
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;
  assign rsp.rem  = rem_r;

endmodule

>>> dv/tb_inner_hair_cell_synapse_top.sv
module tb_inner_hair_cell_synapse_top;
  import ihcs_pkg::*;

  localparam int          NCH      = 64;
  localparam logic [63:0] FULL     = 64'd1073741824;
  localparam logic [63:0] M32      = 64'hFFFF_FFFF;
  localparam int          SETTLE   = 400;
  localparam int          MAX_CYC  = 1000000;

  typedef struct {
    logic              kind;
    logic [5:0]        channel;
    logic signed [31:0] stimulus;
  } syn_item_t;

  typedef struct {
    logic [5:0]  channel;
    logic [31:0] prob;
  } syn_result_t;

  logic clk, rst_n;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [31:0] cfg_data;
  logic in_valid, in_ready, in_kind;
  logic [5:0] in_channel;
  logic signed [31:0] in_stimulus;
  logic out_valid, out_ready;
  logic [5:0] out_channel_out;
  logic [31:0] out_spike_probability;

  inner_hair_cell_synapse_top dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_kind(in_kind),
    .in_channel(in_channel), .in_stimulus(in_stimulus),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_channel_out(out_channel_out), .out_spike_probability(out_spike_probability)
  );

  // shadow of the synapse: registers and per-channel stores
  logic [63:0] syn_reg [8];
  logic [31:0] pool [NCH];
  logic [31:0] cleft [NCH];
  logic [31:0] store_w [NCH];

  syn_item_t   pending_items[$];
  syn_result_t expected_probs[$];
  int errors = 0;
  int cycles = 0;
  int sent = 0, received = 0, inits_sent = 0, phases_run = 0;
  bit in_took = 0;
  int in_gap = 0, out_gap = 0;
  bit no_idle = 0;

  function automatic logic [31:0] sat(logic [63:0] v);
    return (v > M32) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  function automatic logic [63:0] fmul(logic [63:0] coef, logic [63:0] st);
    logic [63:0] p;
    p = coef[31:0] * st[31:0];
    return p >> 32;
  endfunction

  function automatic logic [31:0] release_k(logic signed [31:0] stim);
    longint t;
    logic [63:0] num, den, quo, prod;
    t = longint'(stim) + longint'(syn_reg[REG_PERM_A]);
    if (t <= 0) return 32'd0;
    num = t;
    den = num + syn_reg[REG_PERM_B];
    quo = 0;
    if (num >= den) begin
      num = num - den;
      quo = 1;
    end
    for (int i = 0; i < 32; i++) begin
      num = num << 1;
      quo = quo << 1;
      if (num >= den) begin
        num = num - den;
        quo = quo | 64'd1;
      end
    end
    prod = syn_reg[REG_RELEASE] * quo;
    return prod[63:32];
  endfunction

  function automatic logic [31:0] spike_of(logic [31:0] c);
    logic [63:0] p;
    p = syn_reg[REG_FIRING] * {32'd0, c};
    return sat(p >> 30);
  endfunction

  function automatic logic [31:0] settle_channel(int ch);
    logic [63:0] k0, lossd, p1, a, lo, qi, t, c0, q0, w0;
    logic [64:0] dsum;
    k0 = release_k(32'sd0);
    lossd = (syn_reg[REG_LOSS_REC] >= syn_reg[REG_RECOVERY]) ?
            syn_reg[REG_LOSS_REC] - syn_reg[REG_RECOVERY] : 64'd0;
    p1 = syn_reg[REG_REPLENISH] * syn_reg[REG_LOSS_REC];
    dsum = {1'b0, p1} + {1'b0, k0 * lossd};
    a = syn_reg[REG_REPLENISH] * k0;
    while (dsum > 65'hFFFF_FFFF) begin
      dsum = dsum >> 1;
      a = a >> 1;
    end
    lo = dsum[63:0];
    if (lo == 0) c0 = 0;
    else begin
      qi = a / lo;
      if (qi > M32) c0 = M32;
      else begin
        t = FULL * qi;
        c0 = (t > M32) ? M32 : sat(t + FULL * (a % lo) / lo);
      end
    end
    if (k0 == 0) q0 = FULL;
    else q0 = sat(c0 * syn_reg[REG_LOSS_REC] / k0);
    t = c0 * syn_reg[REG_RECOVERY];
    if (syn_reg[REG_REPROCESS] == 0) w0 = (t != 0) ? M32 : 64'd0;
    else w0 = sat(t / syn_reg[REG_REPROCESS]);
    cleft[ch] = c0[31:0];
    pool[ch] = q0[31:0];
    store_w[ch] = w0[31:0];
    return spike_of(c0[31:0]);
  endfunction

  function automatic logic [31:0] clamp(longint v);
    if (v < 0) return 32'd0;
    if (v > longint'(M32)) return 32'hFFFF_FFFF;
    return v[31:0];
  endfunction

  function automatic logic [31:0] step_channel(int ch, logic signed [31:0] stim);
    logic [63:0] q, c, w, k, repl, back, eject, uptake, gone;
    q = pool[ch];
    c = cleft[ch];
    w = store_w[ch];
    k = release_k(stim);
    repl = (q < FULL) ? fmul(syn_reg[REG_REPLENISH], FULL - q) : 64'd0;
    back = fmul(syn_reg[REG_REPROCESS], w);
    eject = fmul(k, q);
    uptake = fmul(syn_reg[REG_RECOVERY], c);
    gone = fmul(syn_reg[REG_LOSS_REC], c);
    pool[ch] = clamp(longint'(q) + longint'(repl) - longint'(eject) + longint'(back));
    cleft[ch] = clamp(longint'(c) + longint'(eject) - longint'(gone));
    store_w[ch] = clamp(longint'(w) + longint'(uptake) - longint'(back));
    return spike_of(cleft[ch]);
  endfunction

  function automatic int pick_gap();
    if (no_idle) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(0, 2);
    return $urandom_range(10, 60);
  endfunction

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // input driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      in_took = 0;
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        syn_item_t it;
        it = pending_items.pop_front();
        in_kind <= it.kind;
        in_channel <= it.channel;
        in_stimulus <= it.stimulus;
        in_valid <= 1'b1;
        in_gap = pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stalls
  always @(negedge clk) begin
    if (out_gap > 0) begin
      out_gap--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      out_gap = pick_gap();
    end
  end

  // accepted input transactions go through the shadow model; results are checked
  always @(posedge clk) begin
    cycles++;
    if (cycles > MAX_CYC) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
    if (rst_n && in_valid && in_ready) begin
      syn_result_t r;
      r.channel = in_channel;
      if (int'(in_channel) >= NCH) r.prob = 32'd0;
      else if (in_kind) r.prob = settle_channel(in_channel);
      else r.prob = step_channel(in_channel, in_stimulus);
      expected_probs.push_back(r);
      in_took = 1;
      sent++;
      if (in_kind) inits_sent++;
    end
    if (rst_n && out_valid && out_ready) begin
      received++;
      if (expected_probs.size() == 0) begin
        $error("result with no transaction outstanding: channel %0d", out_channel_out);
        errors++;
      end else begin
        syn_result_t e;
        e = expected_probs.pop_front();
        if (out_channel_out !== e.channel) begin
          $error("channel_out: expected %0d, got %0d", e.channel, out_channel_out);
          errors++;
        end
        if (out_spike_probability !== e.prob) begin
          $error("spike_probability: expected %0h, got %0h", e.prob, out_spike_probability);
          errors++;
        end
      end
    end
  end

  task automatic write_reg(cfg_reg_t idx, logic [31:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    syn_reg[idx] = {32'd0, v};
  endtask

  task automatic end_writes();
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic push(logic kind, logic [5:0] ch, logic signed [31:0] stim);
    syn_item_t it;
    it.kind = kind;
    it.channel = ch;
    it.stimulus = stim;
    pending_items.push_back(it);
  endtask

  task automatic drain();
    while (pending_items.size() > 0 || in_valid || expected_probs.size() > 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic random_items(int n);
    logic [5:0] ch;
    logic signed [31:0] stim;
    int sel;
    for (int i = 0; i < n; i++) begin
      // mostly a few busy channels so stores evolve over long runs
      ch = ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(0, 5));
      sel = $urandom_range(0, 9);
      if (sel < 5) stim = $signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000;
      else if (sel < 7) stim = $urandom_range(0, 32'h1000_0000);
      else stim = $urandom;
      push(($urandom_range(0, 9) == 0), ch, stim);
    end
  endtask

  logic [31:0] preset [7][8];

  initial begin
    // register sets: defaults, no knee, no reprocessing, no release at rest,
    // all maxed, all zero, random
    preset[0] = '{32'd6553600, 32'd393216000, 32'd85899346, 32'd216895,
                  32'd2847930, 32'd282604986, 32'd389979169, 32'h8000_0000};
    preset[1] = '{32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'd216895,
                  32'd2847930, 32'd282604986, 32'd389979169, 32'h8000_0000};
    preset[2] = '{32'd6553600, 32'd393216000, 32'd85899346, 32'd9000000,
                  32'd0, 32'd282604986, 32'd389979169, 32'hFFFF_FFFF};
    preset[3] = '{32'd0, 32'd393216000, 32'd85899346, 32'd216895,
                  32'd2847930, 32'd389979169, 32'd282604986, 32'h4000_0000};
    preset[4] = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
    preset[5] = '{32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0};
    for (int r = 0; r < 8; r++) preset[6][r] = $urandom;

    for (int i = 0; i < NCH; i++) begin
      pool[i] = 0;
      cleft[i] = 0;
      store_w[i] = 0;
    end
    for (int r = 0; r < 8; r++) syn_reg[r] = preset[0][r];
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_PERM_A;
    cfg_data = 0;
    in_valid = 1'b0;
    in_kind = 1'b0;
    in_channel = 0;
    in_stimulus = 0;
    out_ready = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // samples on untouched stores first, reset defaults in force
    push(1'b0, 6'd0, 32'sd0);
    push(1'b0, 6'd63, 32'h7FFF_FFFF);
    drain();

    for (int p = 0; p < 7; p++) begin
      phases_run++;
      for (int r = 0; r < 8; r++) write_reg(cfg_reg_t'(r), preset[p][r]);
      end_writes();
      no_idle = (p == 3);
      push(1'b1, 6'd0, 32'sh1234_5678);
      push(1'b1, 6'd63, 32'sd0);
      push(1'b0, 6'd0, 32'sh8000_0000);
      push(1'b0, 6'd63, 32'sh7FFF_FFFF);
      push(1'b0, 6'd0, -$signed(preset[p][REG_PERM_A]));
      random_items(55);
      drain();
    end

    $display("%0d transactions sent (%0d initialise), %0d results checked",
             sent, inits_sent, received);
    $display("%0d register settings including all-zero and all-ones", phases_run);
    if (errors == 0 && expected_probs.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
